@@ sv/cpp_pkg.sv @@
// shared types, constants and permutation functions for the chained permutation prf
package cpp_pkg;

   localparam int NBITS      = 257;
   localparam int ROUNDS     = 8;
   localparam int WORD_W     = 64;
   localparam int KEY_WORDS  = 4;
   localparam int NWORDS     = 5;
   localparam int WIDX_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int REQ_W      = 2;
   localparam int PAIRS      = 32;
   localparam int SHUF_MUL   = 121;
   localparam int MIX_TAP_A  = 3;
   localparam int MIX_TAP_B  = 10;
   localparam int ROUND_W    = $clog2(ROUNDS + 2);
   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(NWORDS - 1);

   typedef logic [NBITS-1:0] state_type;

   typedef enum logic [REQ_W-1:0] {
      REQ_INIT    = 2'd0,
      REQ_ABSORB  = 2'd1,
      REQ_SQUEEZE = 2'd2,
      REQ_UNUSED  = 2'd3
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY0    = 3'd0,
      CSR_KEY1    = 3'd1,
      CSR_KEY2    = 3'd2,
      CSR_KEY3    = 3'd3,
      CSR_KEY_TOP = 3'd4
   } csr_index_type;

   typedef struct packed {
      req_kind_type        kind;
      logic [WORD_W-1:0]   diversifier;
   } item_type;

   function automatic logic has_rc(input logic [ROUND_W-1:0] r);
      return (r == ROUND_W'(1)) || (r == ROUND_W'(3)) || (r == ROUND_W'(4)) ||
             (r == ROUND_W'(7)) || (r == ROUND_W'(8));
   endfunction

   function automatic state_type perm_round(input state_type x, input logic rc);
      state_type t;
      state_type m;
      state_type y;
      for (int i = 0; i < NBITS; i++) begin
         t[i] = x[(i * SHUF_MUL) % NBITS];
      end
      for (int i = 0; i < NBITS; i++) begin
         m[i] = t[i] ^ t[(i + MIX_TAP_A) % NBITS] ^ t[(i + MIX_TAP_B) % NBITS];
      end
      m[0] = m[0] ^ rc;
      for (int i = 0; i < NBITS; i++) begin
         y[i] = m[i] ^ (~m[(i + 1) % NBITS] & m[(i + 2) % NBITS]);
      end
      return y;
   endfunction

   // one-hot pair encoding of the diversifier, top bit marks a squeeze
   function automatic state_type encode(input logic [WORD_W-1:0] d, input logic squeeze);
      state_type e;
      e = '0;
      for (int p = 0; p < PAIRS; p++) begin
         e[p]             = ~d[2*p] & ~d[2*p+1];
         e[PAIRS + p]     = ~d[2*p] &  d[2*p+1];
         e[2*PAIRS + p]   =  d[2*p] & ~d[2*p+1];
         e[3*PAIRS + p]   =  d[2*p] &  d[2*p+1];
      end
      e[NBITS-1] = squeeze;
      return e;
   endfunction

endpackage

@@ sv/cpp_intf.sv @@
// valid/ready channel interfaces for requests, result words and register writes
interface cpp_req_if import cpp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [REQ_W-1:0]     req_type;
   logic [WORD_W-1:0]    diversifier;
   modport source(output valid, output req_type, output diversifier, input ready);
   modport sink(input valid, input req_type, input diversifier, output ready);
endinterface

interface cpp_rsp_if import cpp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WORD_W-1:0]    out_word;
   logic [WIDX_W-1:0]    word_index;
   logic                 last;
   modport source(output valid, output out_word, output word_index, output last, input ready);
   modport sink(input valid, input out_word, input word_index, input last, output ready);
endinterface

interface cpp_csr_if import cpp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [WORD_W-1:0]    data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

@@ sv/cpp_front.sv @@
// request intake: drops unused codes and queues items for the permutation core
module cpp_front import cpp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   cpp_req_if.sink  req_ch,
   output logic     q_valid,
   output item_type q_item,
   input  logic     q_ready
);

   item_type                fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    accept;
   logic                    push;
   logic                    pop;
   item_type                new_item;

   always_comb begin
      req_ch.ready = (count_ff != FIFO_CNT_W'(FIFO_DEPTH));
      accept       = req_ch.valid && req_ch.ready;
      new_item     = '{kind: req_kind_type'(req_ch.req_type), diversifier: req_ch.diversifier};
      push         = accept && (new_item.kind != REQ_UNUSED);
      q_valid      = (count_ff != '0);
      q_item       = fifo_ff[rd_ptr_ff];
      pop          = q_valid && q_ready;
      wr_ptr_in    = push ? wr_ptr_ff + FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in    = pop ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in     = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= new_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("queue count beyond depth");

   a_no_unused_queued: assert property (@(posedge clock) disable iff (reset)
      q_valid |-> (q_item.kind != REQ_UNUSED))
      else $error("unused request code reached the core");

endmodule

@@ sv/cpp_core.sv @@
// key registers, chained state and the iterated two-rounds-per-cycle permutation
module cpp_core import cpp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cpp_csr_if.sink   csr_ch,
   input  logic      q_valid,
   input  item_type  q_item,
   output logic      q_ready,
   output logic      res_valid,
   output state_type res_data,
   input  logic      res_ready
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_RUN  = 3'b010,
      S_HOLD = 3'b100
   } core_state_type;

   core_state_type                   st_ff, st_in;
   logic [KEY_WORDS-1:0][WORD_W-1:0] key_ff, key_in;
   logic                             key_top_ff, key_top_in;
   state_type                        chain_ff, chain_in;
   state_type                        work_ff, work_in;
   state_type                        orig_ff, orig_in;
   logic [ROUND_W-1:0]               round_ff, round_in;
   logic                             squeeze_ff, squeeze_in;
   logic [ROUND_W-1:0]               round_nx;
   state_type                        load_x;
   state_type                        one_r;
   state_type                        two_r;
   state_type                        result;
   logic                             final_step;

   always_comb begin
      csr_ch.ready = 1'b1;
      key_in       = key_ff;
      key_top_in   = key_top_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_KEY0:    key_in[0]  = csr_ch.data;
            CSR_KEY1:    key_in[1]  = csr_ch.data;
            CSR_KEY2:    key_in[2]  = csr_ch.data;
            CSR_KEY3:    key_in[3]  = csr_ch.data;
            CSR_KEY_TOP: key_top_in = csr_ch.data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      load_x     = (q_item.kind == REQ_INIT) ? {key_top_ff, key_ff}
                 : chain_ff ^ encode(q_item.diversifier, q_item.kind == REQ_SQUEEZE);
      round_nx   = round_ff + ROUND_W'(1);
      one_r      = perm_round(work_ff, has_rc(round_ff));
      two_r      = (round_nx <= ROUND_W'(ROUNDS)) ? perm_round(one_r, has_rc(round_nx)) : one_r;
      result     = two_r ^ orig_ff;
      final_step = (st_ff == S_RUN) && (round_nx >= ROUND_W'(ROUNDS));

      q_ready    = (st_ff == S_IDLE);
      res_valid  = (final_step && squeeze_ff) || (st_ff == S_HOLD);
      res_data   = (st_ff == S_HOLD) ? work_ff : result;

      st_in      = st_ff;
      chain_in   = chain_ff;
      work_in    = work_ff;
      orig_in    = orig_ff;
      round_in   = round_ff;
      squeeze_in = squeeze_ff;

      unique case (st_ff)
         S_IDLE: begin
            if (q_valid) begin
               work_in    = load_x;
               orig_in    = load_x;
               round_in   = ROUND_W'(1);
               squeeze_in = (q_item.kind == REQ_SQUEEZE);
               st_in      = S_RUN;
            end
         end
         S_RUN: begin
            work_in  = two_r;
            round_in = round_ff + ROUND_W'(2);
            if (final_step) begin
               if (!squeeze_ff) begin
                  chain_in = result;
                  st_in    = S_IDLE;
               end else if (res_ready) begin
                  st_in = S_IDLE;
               end else begin
                  work_in = result;
                  st_in   = S_HOLD;
               end
            end
         end
         S_HOLD: begin
            if (res_ready) begin
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= S_IDLE;
         key_ff     <= '0;
         key_top_ff <= 1'b0;
         chain_ff   <= '0;
      end else begin
         st_ff      <= st_in;
         key_ff     <= key_in;
         key_top_ff <= key_top_in;
         chain_ff   <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff    <= work_in;
      orig_ff    <= orig_in;
      round_ff   <= round_in;
      squeeze_ff <= squeeze_in;
   end

   a_squeeze_keeps_chain: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_RUN && squeeze_ff) |=> $stable(chain_ff))
      else $error("squeeze changed the chained state");

   a_load_starts_run: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_IDLE && q_valid) |=> (st_ff == S_RUN && round_ff == ROUND_W'(1)))
      else $error("accepted item did not start the permutation");

endmodule

@@ sv/cpp_drain.sv @@
// output buffer that splits a squeezed value into five result words
module cpp_drain import cpp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  state_type in_data,
   output logic      in_ready,
   cpp_rsp_if.source rsp_ch
);

   state_type           buf_ff, buf_in;
   logic                full_ff, full_in;
   logic [WIDX_W-1:0]   idx_ff, idx_in;
   logic                fire_out;
   logic                last_word;

   always_comb begin
      last_word  = (idx_ff == LAST_WORD);
      fire_out   = full_ff && rsp_ch.ready;
      in_ready   = !full_ff || (fire_out && last_word);

      rsp_ch.valid      = full_ff;
      rsp_ch.word_index = idx_ff;
      rsp_ch.last       = last_word;
      unique case (idx_ff)
         3'd0:    rsp_ch.out_word = buf_ff[0*WORD_W +: WORD_W];
         3'd1:    rsp_ch.out_word = buf_ff[1*WORD_W +: WORD_W];
         3'd2:    rsp_ch.out_word = buf_ff[2*WORD_W +: WORD_W];
         3'd3:    rsp_ch.out_word = buf_ff[3*WORD_W +: WORD_W];
         3'd4:    rsp_ch.out_word = {{(WORD_W-1){1'b0}}, buf_ff[NBITS-1]};
         default: rsp_ch.out_word = '0;
      endcase

      buf_in  = buf_ff;
      full_in = full_ff;
      idx_in  = idx_ff;
      if (in_valid && in_ready) begin
         buf_in  = in_data;
         full_in = 1'b1;
         idx_in  = '0;
      end else if (fire_out) begin
         if (last_word) begin
            full_in = 1'b0;
         end else begin
            idx_in = idx_ff + WIDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         full_ff <= full_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   a_stall_holds_word: assert property (@(posedge clock) disable iff (reset)
      (full_ff && !rsp_ch.ready) |=> (full_ff && $stable(idx_ff)))
      else $error("word index moved while stalled");

endmodule

@@ sv/chained_permutation_prf.sv @@
// top level of the keyed chained permutation prf
//
//   channel  dir   payload                              accepted when
//   req_ch   in    req_type, diversifier                valid && ready
//   rsp_ch   out   out_word, word_index, last           valid && ready
//   csr_ch   in    index, data (key registers 0..4)     valid && ready (ready always high)
//
// an item passes through the core as a load step in the idle state, then the run
// state, in which the permutation unit applies two of the eight rounds per cycle
// a squeeze then drains five words from the output buffer, one per cycle unless
// rsp_ch stalls it, while the core already works on the next item
// a two-entry queue sits between intake and core; init and absorb give no words
// reset clears key registers, chained state, queue pointers and the buffer's full flag; no clearing pass

module chained_permutation_prf import cpp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cpp_req_if.sink   req_ch,
   cpp_rsp_if.source rsp_ch,
   cpp_csr_if.sink   csr_ch
);

   logic      q_valid;
   item_type  q_item;
   logic      q_ready;
   logic      res_valid;
   state_type res_data;
   logic      res_ready;

   cpp_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_ready (q_ready)
   );

   cpp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_ch    (csr_ch),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_ready   (q_ready),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_ready (res_ready)
   );

   cpp_drain u_drain (
      .clock    (clock),
      .reset    (reset),
      .in_valid (res_valid),
      .in_data  (res_data),
      .in_ready (res_ready),
      .rsp_ch   (rsp_ch)
   );

endmodule

@@ tb/sv/prf_checker.sv @@
// checker for the chained permutation prf: predicts squeeze words and compares them
module prf_checker import cpp_pkg::*; (
   input  logic clock,
   input  logic reset,
   cpp_req_if   req_ch,
   cpp_rsp_if   rsp_ch,
   cpp_csr_if   csr_ch,
   output int   mismatches,
   output int   words_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;
   // rounds 1, 3, 4, 7 and 8 carry the constant
   localparam logic [ROUNDS:0] RC_ROUNDS = 9'b110011010;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [WIDX_W-1:0] index;
      logic              last;
   } squeeze_word_type;

   logic [KEY_WORDS-1:0][WORD_W-1:0] key_words;
   logic                             key_top;
   state_type                        chain;
   squeeze_word_type                 squeeze_words [$];

   function automatic state_type permute_ff(input state_type x);
      state_type cur;
      state_type shuffled;
      state_type mixed;
      cur = x;
      for (int r = 1; r <= ROUNDS; r++) begin
         for (int i = 0; i < NBITS; i++) begin
            shuffled[i] = cur[(i * SHUF_MUL) % NBITS];
         end
         for (int i = 0; i < NBITS; i++) begin
            mixed[i] = shuffled[i] ^ shuffled[(i + MIX_TAP_A) % NBITS]
                       ^ shuffled[(i + MIX_TAP_B) % NBITS];
         end
         mixed[0] = mixed[0] ^ RC_ROUNDS[r];
         for (int i = 0; i < NBITS; i++) begin
            cur[i] = mixed[i] ^ (~mixed[(i + 1) % NBITS] & mixed[(i + 2) % NBITS]);
         end
      end
      return cur ^ x;
   endfunction

   // each diversifier pair selects one of four 32-bit lanes
   function automatic state_type pair_onehot(input logic [WORD_W-1:0] d, input logic squeeze);
      state_type e;
      int        lane;
      e = '0;
      for (int p = 0; p < PAIRS; p++) begin
         lane = int'({d[2*p], d[2*p+1]});
         e[lane * PAIRS + p] = 1'b1;
      end
      e[NBITS-1] = squeeze;
      return e;
   endfunction

   always @(posedge clock) begin
      state_type        squeezed;
      squeeze_word_type got;
      squeeze_word_type want;
      if (reset) begin
         key_words = '0;
         key_top = 1'b0;
         chain = '0;
         squeeze_words.delete();
         mismatches = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.out_word, rsp_ch.word_index, rsp_ch.last};
            if (squeeze_words.size() == 0) begin
               if (mismatches < REPORT_LIMIT) begin
                  $display("%0t: unexpected word %h index %0d last %0b",
                           $realtime, got.word, got.index, got.last);
               end
               mismatches++;
            end else begin
               want = squeeze_words.pop_front();
               if (got !== want) begin
                  if (mismatches < REPORT_LIMIT) begin
                     $display("%0t: expected word %h index %0d last %0b, got %h index %0d last %0b",
                              $realtime, want.word, want.index, want.last,
                              got.word, got.index, got.last);
                  end
                  mismatches++;
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_KEY0:    key_words[0] = csr_ch.data;
               CSR_KEY1:    key_words[1] = csr_ch.data;
               CSR_KEY2:    key_words[2] = csr_ch.data;
               CSR_KEY3:    key_words[3] = csr_ch.data;
               CSR_KEY_TOP: key_top = csr_ch.data[0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            case (req_ch.req_type)
               REQ_INIT: chain = permute_ff({key_top, key_words});
               REQ_ABSORB: chain = permute_ff(chain ^ pair_onehot(req_ch.diversifier, 1'b0));
               REQ_SQUEEZE: begin
                  squeezed = permute_ff(chain ^ pair_onehot(req_ch.diversifier, 1'b1));
                  for (int k = 0; k < NWORDS; k++) begin
                     want.word = (k == NWORDS - 1) ? WORD_W'(squeezed[NBITS-1])
                                                   : squeezed[k*WORD_W +: WORD_W];
                     want.index = WIDX_W'(k);
                     want.last = (k == NWORDS - 1);
                     squeeze_words.push_back(want);
                  end
               end
               default: ;
            endcase
         end
      end
      words_due = squeeze_words.size();
   end

endmodule

@@ tb/sv/tb.sv @@
// testbench top for the chained permutation prf: clock, reset, stimulus and verdict
module tb import cpp_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 400;
   localparam int MAX_GAP       = 10;
   localparam int PHASE_ITEMS   = 22;
   localparam logic [CSR_IDX_W-1:0] UNMAPPED_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] UNMAPPED_HI = 3'd7;

   logic clock;
   logic reset;
   int   mismatches;
   int   words_due;
   int   cycles;
   bit   steady;
   bit   hold_rsp;

   cpp_req_if req_ch();
   cpp_rsp_if rsp_ch();
   cpp_csr_if csr_ch();

   chained_permutation_prf dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   prf_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_ch     (csr_ch),
      .mismatches (mismatches),
      .words_due  (words_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [WORD_W-1:0] rand_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_kind_type rand_kind();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 2) return REQ_INIT;
      if (pick < 9) return REQ_ABSORB;
      if (pick < 18) return REQ_SQUEEZE;
      return REQ_UNUSED;
   endfunction

   task automatic send(input req_kind_type kind, input logic [WORD_W-1:0] div);
      int gap;
      gap = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.diversifier <= div;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic load_key(input logic [KEY_WORDS-1:0][WORD_W-1:0] words,
                           input logic [WORD_W-1:0] top_data, input bit stray);
      csr_index_type slot [KEY_WORDS] = '{CSR_KEY0, CSR_KEY1, CSR_KEY2, CSR_KEY3};
      if (stray) begin
         csr_write(UNMAPPED_HI, rand_word());
         csr_write(UNMAPPED_LO, '1);
      end
      for (int w = 0; w < KEY_WORDS; w++) begin
         csr_write(slot[w], words[w]);
      end
      csr_write(CSR_KEY_TOP, top_data);
      csr_ch.valid <= 1'b0;
   endtask

   // wait until every expected word is out, then let the core finish
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (words_due != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase();
      load_key({rand_word(), rand_word(), rand_word(), rand_word()}, rand_word(),
               bit'($urandom_range(0, 1)));
      send(REQ_INIT, rand_word());
      repeat (PHASE_ITEMS) send(rand_kind(), rand_word());
      settle();
   endtask

   // result side: random stalls plus one long hold-off
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = steady ? 0 : $urandom_range(0, MAX_GAP);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            gap = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.req_type <= REQ_INIT;
      req_ch.diversifier <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= CSR_KEY0;
      csr_ch.data <= '0;
      steady = 1'b0;
      hold_rsp = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset key and all-zero state
      send(REQ_SQUEEZE, '0);
      send(REQ_ABSORB, '1);
      send(REQ_SQUEEZE, '1);
      send(REQ_UNUSED, 64'h5555_5555_5555_5555);
      send(REQ_SQUEEZE, '1);
      send(REQ_INIT, 64'hdead_beef_0bad_f00d);
      send(REQ_SQUEEZE, 64'haaaa_aaaa_aaaa_aaaa);
      send(REQ_ABSORB, 64'h0123_4567_89ab_cdef);
      send(REQ_SQUEEZE, '0);
      settle();

      // all-ones key, unmapped register writes
      load_key('1, '1, 1'b1);
      send(REQ_INIT, '0);
      send(REQ_SQUEEZE, '0);
      send(REQ_ABSORB, 64'h5555_5555_5555_5555);
      send(REQ_SQUEEZE, '1);
      send(REQ_UNUSED, '1);
      send(REQ_SQUEEZE, 64'hfedc_ba98_7654_3210);
      send(REQ_INIT, '1);
      send(REQ_SQUEEZE, '0);
      settle();

      // zero key written back, top bit cleared with upper data bits set
      load_key('0, 64'hffff_ffff_ffff_fffe, 1'b0);
      send(REQ_INIT, '1);
      send(REQ_SQUEEZE, '1);
      send(REQ_ABSORB, '0);
      send(REQ_SQUEEZE, '0);
      settle();

      hold_rsp = 1'b1;
      random_phase();
      steady = 1'b1;
      random_phase();
      steady = 1'b0;
      random_phase();
      random_phase();

      if (mismatches == 0 && words_due == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ chained_permutation_prf.f @@
sv/cpp_pkg.sv
sv/cpp_intf.sv
sv/cpp_front.sv
sv/cpp_core.sv
sv/cpp_drain.sv
sv/chained_permutation_prf.sv
tb/sv/prf_checker.sv
tb/sv/tb.sv
